FILE: sv/nvbb_pkg.sv
// ----------------------------------------------------------------------------
// nvbb_pkg
// Shared constants, types and helper functions of the noise volume box blur.
// ----------------------------------------------------------------------------
package nvbb_pkg;

   // Volume geometry.
   localparam int EDGE    = 32;
   localparam int COORD_W = $clog2(EDGE);
   localparam int VOXELS  = EDGE * EDGE * EDGE;
   localparam int ADDR_W  = $clog2(VOXELS);

   // Widths of the channel fields.
   localparam int IN_COORD_W = 5;
   localparam int VOXEL_W    = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // Generator constants.
   localparam logic [31:0] LCG_MUL    = 32'd1664525;
   localparam logic [31:0] LCG_ADD    = 32'd1013904223;
   localparam logic [31:0] SEED_RESET = 32'd1337;
   localparam logic [1:0]  PASS_RESET = 2'd2;

   // Sum of 27 bytes and its division by 27 as a reciprocal multiply.
   // 9710 / 2^18 is exact for every sum up to 27 * 255.
   localparam int          SUM_W       = $clog2(27 * 255 + 1);
   localparam int          DIV_MUL_W   = 14;
   localparam logic [DIV_MUL_W-1:0] DIV27_MUL = 14'd9710;
   localparam int          DIV27_SHIFT = 18;
   localparam int          PROD_W      = SUM_W + DIV_MUL_W;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_SEED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PASS_COUNT = 1'b1;

   // Tap positions along one axis.
   localparam logic [1:0] TAP_LOW  = 2'd0;
   localparam logic [1:0] TAP_MID  = 2'd1;
   localparam logic [1:0] TAP_HIGH = 2'd2;

   typedef struct packed {
      logic accept;
      logic start_gen;
      logic fill_step;
      logic tap_issue;
      logic divide;
      logic write_back;
      logic capture_rd;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic last_voxel;
      logic last_tap;
      logic no_pass;
      logic last_pass;
   } status_type;

   // Neighbour coordinate with wraparound at the volume edges.
   function automatic logic [COORD_W-1:0] wrap_coord(input logic [COORD_W-1:0] c,
                                                     input logic [1:0] t);
      logic [COORD_W-1:0] r;
      r = c;
      if (t == TAP_LOW) begin
         r = (c == '0) ? COORD_W'(EDGE - 1) : c - COORD_W'(1);
      end else if (t == TAP_HIGH) begin
         r = (c == COORD_W'(EDGE - 1)) ? '0 : c + COORD_W'(1);
      end
      return r;
   endfunction

   // Linear voxel address with x running fastest.
   function automatic logic [ADDR_W-1:0] vox_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y,
                                                  input logic [COORD_W-1:0] z);
      return ADDR_W'(z) * ADDR_W'(EDGE * EDGE) + ADDR_W'(y) * ADDR_W'(EDGE)
             + ADDR_W'(x);
   endfunction

endpackage

FILE: sv/nvbb_if.sv
// ----------------------------------------------------------------------------
// nvbb_if
// Channel interfaces of the noise volume box blur: request, response and
// configuration write.
// ----------------------------------------------------------------------------
interface nvbb_req_if;
   logic                               valid;
   logic                               ready;
   logic                               mode;
   logic [nvbb_pkg::IN_COORD_W-1:0]    coord_x;
   logic [nvbb_pkg::IN_COORD_W-1:0]    coord_y;
   logic [nvbb_pkg::IN_COORD_W-1:0]    coord_z;

   modport source (output valid, mode, coord_x, coord_y, coord_z, input ready);
   modport sink   (input valid, mode, coord_x, coord_y, coord_z, output ready);
endinterface

interface nvbb_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [nvbb_pkg::VOXEL_W-1:0]       voxel_value;
   logic                               generated;

   modport source (output valid, voxel_value, generated, input ready);
   modport sink   (input valid, voxel_value, generated, output ready);
endinterface

interface nvbb_csr_if;
   logic                               valid;
   logic                               ready;
   logic [nvbb_pkg::CSR_IDX_W-1:0]     index;
   logic [nvbb_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/nvbb_ctrl.sv
// ----------------------------------------------------------------------------
// nvbb_ctrl
// Sequencer of the noise volume box blur: steps the fill, the per-voxel tap
// sweep, the division and write-back and the read capture, and owns the response valid flag.
// ----------------------------------------------------------------------------
module nvbb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_mode,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  nvbb_pkg::status_type status,
   output nvbb_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_FILL    = 3'd1;
   localparam logic [2:0] ST_TAP     = 3'd2;
   localparam logic [2:0] ST_TAIL    = 3'd3;
   localparam logic [2:0] ST_DIV     = 3'd4;
   localparam logic [2:0] ST_WB      = 3'd5;
   localparam logic [2:0] ST_RD_WAIT = 3'd6;
   localparam logic [2:0] ST_DONE    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept    = 1'b1;
               cmd.start_gen = !req_mode;
               state_in      = req_mode ? ST_RD_WAIT : ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.last_voxel) begin
               state_in = status.no_pass ? ST_DONE : ST_TAP;
            end
         end
         ST_TAP: begin
            cmd.tap_issue = 1'b1;
            if (status.last_tap) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            // The last tap's byte lands in the accumulator here.
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.divide = 1'b1;
            state_in   = ST_WB;
         end
         ST_WB: begin
            cmd.write_back = 1'b1;
            if (status.last_voxel && status.last_pass) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_TAP;
            end
         end
         ST_RD_WAIT: begin
            cmd.capture_rd = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/nvbb_datapath.sv
// ----------------------------------------------------------------------------
// nvbb_datapath
// Datapath of the noise volume box blur: configuration registers, generator,
// two volume banks used in turn, voxel and tap counters, accumulator,
// divider by 27 and the response payload.
// ----------------------------------------------------------------------------
module nvbb_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  nvbb_pkg::cmd_type                     cmd,
   output nvbb_pkg::status_type                  status,
   input  logic                                  csr_write,
   input  logic [nvbb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [nvbb_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic                                  req_mode,
   input  logic [nvbb_pkg::IN_COORD_W-1:0]       req_coord_x,
   input  logic [nvbb_pkg::IN_COORD_W-1:0]       req_coord_y,
   input  logic [nvbb_pkg::IN_COORD_W-1:0]       req_coord_z,
   output logic [nvbb_pkg::VOXEL_W-1:0]          rsp_voxel_value,
   output logic                                  rsp_generated
);

   localparam int CW = nvbb_pkg::COORD_W;
   localparam int AW = nvbb_pkg::ADDR_W;
   localparam int VW = nvbb_pkg::VOXEL_W;
   localparam int SW = nvbb_pkg::SUM_W;
   localparam int PW = nvbb_pkg::PROD_W;

   // Volume banks; one holds the current volume, the other takes a pass's output.
   logic [VW-1:0] bank_a [nvbb_pkg::VOXELS];
   logic [VW-1:0] bank_b [nvbb_pkg::VOXELS];

   logic [31:0]   seed_ff, seed_in;
   logic [1:0]    passes_ff, passes_in;
   logic [31:0]   gen_ff, gen_in, gen_next;
   logic [1:0]    pass_left_ff, pass_left_in;
   logic          bank_ff, bank_in;
   logic [CW-1:0] vx_ff, vy_ff, vz_ff, vx_in, vy_in, vz_in;
   logic [1:0]    tx_ff, ty_ff, tz_ff, tx_in, ty_in, tz_in;
   logic          rv_ff, rv_in;
   logic [SW-1:0] acc_ff, acc_in;
   logic [VW-1:0] quot_ff, quot_in;
   logic          mode_ff, mode_in;
   logic          inrange_ff, inrange_in;
   logic [VW-1:0] rd_val_ff, rd_val_in;
   logic [VW-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_gen_ff, rsp_gen_in;

   logic [VW-1:0] rdata_a_ff, rdata_b_ff, rdata;
   logic [AW-1:0] rd_addr, wr_addr, tap_addr, req_addr;
   logic          we_a, we_b;
   logic [VW-1:0] wd_a;
   logic [PW-1:0] prod;
   logic          last_x, last_y, last_z;

   assign last_x = (vx_ff == CW'(nvbb_pkg::EDGE - 1));
   assign last_y = (vy_ff == CW'(nvbb_pkg::EDGE - 1));
   assign last_z = (vz_ff == CW'(nvbb_pkg::EDGE - 1));

   assign status.last_voxel = last_x && last_y && last_z;
   assign status.last_tap   = (tx_ff == nvbb_pkg::TAP_HIGH) && (ty_ff == nvbb_pkg::TAP_HIGH)
                              && (tz_ff == nvbb_pkg::TAP_HIGH);
   assign status.no_pass    = (pass_left_ff == 2'd0);
   assign status.last_pass  = (pass_left_ff == 2'd1);

   assign gen_next = gen_ff * nvbb_pkg::LCG_MUL + nvbb_pkg::LCG_ADD;

   assign tap_addr = nvbb_pkg::vox_addr(nvbb_pkg::wrap_coord(vx_ff, tx_ff),
                                        nvbb_pkg::wrap_coord(vy_ff, ty_ff),
                                        nvbb_pkg::wrap_coord(vz_ff, tz_ff));
   assign req_addr = nvbb_pkg::vox_addr(CW'(req_coord_x), CW'(req_coord_y),
                                        CW'(req_coord_z));
   assign rd_addr  = cmd.tap_issue ? tap_addr : req_addr;
   assign wr_addr  = nvbb_pkg::vox_addr(vx_ff, vy_ff, vz_ff);

   assign we_a  = cmd.fill_step || (cmd.write_back && bank_ff);
   assign we_b  = cmd.write_back && !bank_ff;
   assign wd_a  = cmd.fill_step ? gen_next[31:24] : quot_ff;
   assign rdata = bank_ff ? rdata_b_ff : rdata_a_ff;
   assign prod  = PW'(acc_ff) * PW'(nvbb_pkg::DIV27_MUL);

   always_ff @(posedge clock) begin
      if (we_a) begin
         bank_a[wr_addr] <= wd_a;
      end
      rdata_a_ff <= bank_a[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         bank_b[wr_addr] <= quot_ff;
      end
      rdata_b_ff <= bank_b[rd_addr];
   end

   always_comb begin
      seed_in      = seed_ff;
      passes_in    = passes_ff;
      gen_in       = gen_ff;
      pass_left_in = pass_left_ff;
      bank_in      = bank_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      vz_in        = vz_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      tz_in        = tz_ff;
      rv_in        = cmd.tap_issue;
      acc_in       = rv_ff ? acc_ff + SW'(rdata) : acc_ff;
      quot_in      = quot_ff;
      mode_in      = mode_ff;
      inrange_in   = inrange_ff;
      rd_val_in    = rd_val_ff;
      rsp_value_in = rsp_value_ff;
      rsp_gen_in   = rsp_gen_ff;

      if (csr_write) begin
         unique case (csr_index)
            nvbb_pkg::CSR_NOISE_SEED: seed_in   = csr_data;
            nvbb_pkg::CSR_PASS_COUNT: passes_in = csr_data[1:0];
            default:                  seed_in   = seed_ff;
         endcase
      end

      if (cmd.accept) begin
         mode_in    = req_mode;
         inrange_in = (int'(req_coord_x) < nvbb_pkg::EDGE)
                      && (int'(req_coord_y) < nvbb_pkg::EDGE)
                      && (int'(req_coord_z) < nvbb_pkg::EDGE);
      end

      if (cmd.start_gen) begin
         gen_in       = seed_ff;
         pass_left_in = passes_ff;
         bank_in      = 1'b0;
         vx_in        = '0;
         vy_in        = '0;
         vz_in        = '0;
         tx_in        = nvbb_pkg::TAP_LOW;
         ty_in        = nvbb_pkg::TAP_LOW;
         tz_in        = nvbb_pkg::TAP_LOW;
         acc_in       = '0;
      end

      if (cmd.fill_step) begin
         gen_in = gen_next;
      end

      // Voxel walk, x fastest, shared by the fill and the smoothing passes.
      if (cmd.fill_step || cmd.write_back) begin
         vx_in = last_x ? '0 : vx_ff + CW'(1);
         if (last_x) begin
            vy_in = last_y ? '0 : vy_ff + CW'(1);
            if (last_y) begin
               vz_in = last_z ? '0 : vz_ff + CW'(1);
            end
         end
      end

      if (cmd.tap_issue) begin
         tx_in = (tx_ff == nvbb_pkg::TAP_HIGH) ? nvbb_pkg::TAP_LOW : tx_ff + 2'd1;
         if (tx_ff == nvbb_pkg::TAP_HIGH) begin
            ty_in = (ty_ff == nvbb_pkg::TAP_HIGH) ? nvbb_pkg::TAP_LOW : ty_ff + 2'd1;
            if (ty_ff == nvbb_pkg::TAP_HIGH) begin
               tz_in = (tz_ff == nvbb_pkg::TAP_HIGH) ? nvbb_pkg::TAP_LOW : tz_ff + 2'd1;
            end
         end
      end

      if (cmd.divide) begin
         quot_in = prod[nvbb_pkg::DIV27_SHIFT +: VW];
      end

      if (cmd.write_back) begin
         acc_in = '0;
         if (status.last_voxel) begin
            // The pass is complete: the freshly written bank becomes current.
            bank_in      = !bank_ff;
            pass_left_in = pass_left_ff - 2'd1;
         end
      end

      if (cmd.capture_rd) begin
         rd_val_in = inrange_ff ? rdata : '0;
      end

      if (cmd.load_rsp) begin
         rsp_value_in = mode_ff ? rd_val_ff : '0;
         rsp_gen_in   = !mode_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= nvbb_pkg::SEED_RESET;
         passes_ff    <= nvbb_pkg::PASS_RESET;
         gen_ff       <= '0;
         pass_left_ff <= '0;
         bank_ff      <= 1'b0;
         vx_ff        <= '0;
         vy_ff        <= '0;
         vz_ff        <= '0;
         tx_ff        <= nvbb_pkg::TAP_LOW;
         ty_ff        <= nvbb_pkg::TAP_LOW;
         tz_ff        <= nvbb_pkg::TAP_LOW;
         rv_ff        <= 1'b0;
         mode_ff      <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         passes_ff    <= passes_in;
         gen_ff       <= gen_in;
         pass_left_ff <= pass_left_in;
         bank_ff      <= bank_in;
         vx_ff        <= vx_in;
         vy_ff        <= vy_in;
         vz_ff        <= vz_in;
         tx_ff        <= tx_in;
         ty_ff        <= ty_in;
         tz_ff        <= tz_in;
         rv_ff        <= rv_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      quot_ff      <= quot_in;
      inrange_ff   <= inrange_in;
      rd_val_ff    <= rd_val_in;
      rsp_value_ff <= rsp_value_in;
      rsp_gen_ff   <= rsp_gen_in;
   end

   assign rsp_voxel_value = rsp_value_ff;
   assign rsp_generated   = rsp_gen_ff;

endmodule

FILE: sv/noise_volume_box_blur.sv
// ----------------------------------------------------------------------------
// noise_volume_box_blur
// Smoothed value-noise volume with single-voxel read-back.
// ----------------------------------------------------------------------------
// A generate word reloads the generator from noise_seed, fills the EDGE^3
// byte volume one voxel a cycle and then runs pass_count 3x3x3 wraparound
// averaging passes. Each pass reads the 27 neighbours of a voxel through the
// single read port of the current bank, one per cycle, and then takes the
// last byte into the accumulator, divides by 27 and writes the result back;
// the two banks swap roles after every pass. The response to a generate is
// registered once the fill and all passes are done. The response to a read
// word passes through the bank's read register and the read-value register
// into the response register. One word is in work at a time; the response
// register lets the next word be accepted while a finished response waits.
// Voxels read before any generate hold no defined value. Configuration
// writes are taken at any time but belong in idle periods.
// ----------------------------------------------------------------------------
module noise_volume_box_blur (
   input  logic  clock,
   input  logic  reset,
   nvbb_req_if.sink   req_if,
   nvbb_rsp_if.source rsp_if,
   nvbb_csr_if.sink   csr_if
);

   nvbb_pkg::cmd_type    cmd;
   nvbb_pkg::status_type status;
   logic                 req_ready;
   logic                 rsp_valid;

   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid;
   assign csr_if.ready = 1'b1;

   nvbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_mode  (req_if.mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   nvbb_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_write       (csr_if.valid),
      .csr_index       (csr_if.index),
      .csr_data        (csr_if.data),
      .req_mode        (req_if.mode),
      .req_coord_x     (req_if.coord_x),
      .req_coord_y     (req_if.coord_y),
      .req_coord_z     (req_if.coord_z),
      .rsp_voxel_value (rsp_if.voxel_value),
      .rsp_generated   (rsp_if.generated)
   );

endmodule
